/* rtl/hdbn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDBn line encoder package
// Symbol codes, register indexes and the command item passed from the
// classifying front end to the window back end.
// ----------------------------------------------------------------------------
package hdbn_pkg;

    typedef logic signed [1:0] t_sym;

    localparam t_sym SYM_ZERO = 2'sb00;
    localparam t_sym SYM_POS  = 2'sb01;
    localparam t_sym SYM_NEG  = 2'sb11;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 3;
    localparam int ZRUN_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZEROS_LIMIT = 2'd0,
        CFG_FIRST_V_NEG = 2'd1,
        CFG_FIRST_MARK  = 2'd2
    } t_cfg_idx;

    localparam logic [2:0] RST_ZEROS_LIMIT = 3'd3;
    localparam logic       RST_FIRST_V_NEG = 1'b1;
    localparam t_sym       RST_FIRST_MARK  = SYM_POS;

    // command fields are sized for the widest supported window
    localparam int MAX_N_LIMIT = 15;
    localparam int POS_W       = $clog2(MAX_N_LIMIT + 1);
    localparam int CNT_W       = $clog2(MAX_N_LIMIT + 2);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        t_sym             sym;
        logic             b_pulse;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] b_slot;
        logic [CNT_W-1:0] count;
        logic             eos;
    } t_cmd;

endpackage
`default_nettype wire

/* rtl/hdbn_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDBn front end
// Holds the configuration, classifies each bit as mark, violation or space,
// decides the retroactive B pulse and the number of symbols to release.
// ----------------------------------------------------------------------------
module hdbn_front #(
    parameter int MAX_N = 7
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    input  wire [hdbn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [hdbn_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_data_bit,
    input  wire                            i_end_of_stream,
    input  wire                            i_q_full,
    output logic                           o_q_push,
    output hdbn_pkg::t_cmd                 o_q_cmd
);
    import hdbn_pkg::*;

    localparam int PW = $clog2(MAX_N + 1);
    localparam int CW = $clog2(MAX_N + 2);

    logic [2:0]        r_zlim;
    logic              r_fvn;
    t_sym              r_fmp;

    logic [PW-1:0]     r_fill, n_fill;
    logic [ZRUN_W-1:0] r_zrun, n_zrun;
    logic              r_lp_pos, n_lp_pos;
    logic              r_nvn, n_nvn;

    logic [PW-1:0]     n_lim;
    logic [CW-1:0]     total;
    logic [CW-1:0]     keep;
    logic [CW-1:0]     count;
    t_sym              sym;
    logic              b_pulse;

    always_comb begin
        n_lim    = (32'(r_zlim) > MAX_N) ? PW'(MAX_N) : PW'(r_zlim);
        n_zrun   = r_zrun;
        n_lp_pos = r_lp_pos;
        n_nvn    = r_nvn;
        b_pulse  = 1'b0;
        priority if (i_data_bit) begin
            sym      = r_lp_pos ? SYM_NEG : SYM_POS;
            n_lp_pos = !r_lp_pos;
            n_zrun   = '0;
        end else if (32'(r_zrun) >= 32'(n_lim)) begin
            sym      = r_nvn ? SYM_NEG : SYM_POS;
            b_pulse  = (r_lp_pos != !r_nvn) && (r_fill >= n_lim);
            n_lp_pos = !r_nvn;
            n_zrun   = '0;
            n_nvn    = !r_nvn;
        end else begin
            sym      = SYM_ZERO;
            n_zrun   = r_zrun + 1'b1;
        end
        total = CW'(r_fill) + 1'b1;
        if (i_end_of_stream) begin
            keep = '0;
        end else begin
            keep = (total > CW'(n_lim)) ? CW'(n_lim) : total;
        end
        count  = total - keep;
        n_fill = keep[PW-1:0];
        if (i_end_of_stream) begin
            n_zrun   = '0;
            n_lp_pos = (r_fmp == SYM_NEG);
            n_nvn    = r_fvn;
        end
    end

    assign o_in_stall      = i_q_full;
    assign o_q_push        = i_in_valid && !i_q_full;
    assign o_q_cmd.sym     = sym;
    assign o_q_cmd.b_pulse = b_pulse;
    assign o_q_cmd.pos     = POS_W'(r_fill);
    assign o_q_cmd.b_slot  = POS_W'(r_fill - n_lim);
    assign o_q_cmd.count   = CNT_W'(count);
    assign o_q_cmd.eos     = i_end_of_stream;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zlim <= RST_ZEROS_LIMIT;
            r_fvn  <= RST_FIRST_V_NEG;
            r_fmp  <= RST_FIRST_MARK;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ZEROS_LIMIT: r_zlim <= i_cfg_data;
                CFG_FIRST_V_NEG: r_fvn  <= i_cfg_data[0];
                CFG_FIRST_MARK:  r_fmp  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_zrun   <= '0;
            r_lp_pos <= (RST_FIRST_MARK == SYM_NEG);
            r_nvn    <= RST_FIRST_V_NEG;
        end else if (o_q_push) begin
            r_fill   <= n_fill;
            r_zrun   <= n_zrun;
            r_lp_pos <= n_lp_pos;
            r_nvn    <= n_nvn;
        end
    end

endmodule
`default_nettype wire

/* rtl/hdbn_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDBn command queue
// Short queue of command items between the front end and the back end.
// ----------------------------------------------------------------------------
module hdbn_cmd_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  hdbn_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output hdbn_pkg::t_cmd o_cmd
);
    import hdbn_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                push_ok;
    logic                pop_ok;

    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW + 1)'(push_ok) - (QUEUE_AW + 1)'(pop_ok);
        end
    end

endmodule
`default_nettype wire

/* rtl/hdbn_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDBn back end
// Holds the symbol window, applies each command (new symbol, B pulse) and
// releases the oldest symbols via the output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module hdbn_back #(
    parameter int MAX_N = 7
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  hdbn_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output hdbn_pkg::t_sym   o_symbol,
    output logic             o_final_symbol
);
    import hdbn_pkg::*;

    localparam int PW = $clog2(MAX_N + 1);
    localparam int CW = $clog2(MAX_N + 2);

    t_sym          r_win [MAX_N+1];
    logic [CW-1:0] r_left;
    logic          r_eos;
    logic          r_out_valid;
    t_sym          r_out_sym;
    logic          r_out_final;

    t_sym          ins   [MAX_N+1];
    t_sym          src   [MAX_N+1];
    t_sym          sh    [MAX_N+1];
    logic          run;
    logic          can_out;
    logic          emit;
    logic [CW-1:0] cmd_cnt;
    logic [CW-1:0] src_left;
    logic          src_eos;

    always_comb begin
        ins = r_win;
        ins[i_cmd.pos[PW-1:0]] = i_cmd.sym;
        if (i_cmd.b_pulse) begin
            ins[i_cmd.b_slot[PW-1:0]] = i_cmd.sym;
        end
        run      = (r_left != '0);
        can_out  = !r_out_valid || !i_out_stall;
        cmd_cnt  = i_cmd.count[CW-1:0];
        o_pop    = i_q_valid && !run && ((cmd_cnt == '0) || can_out);
        emit     = can_out && (run || (i_q_valid && (cmd_cnt != '0)));
        src      = run ? r_win : ins;
        src_left = run ? r_left : cmd_cnt;
        src_eos  = run ? r_eos : i_cmd.eos;
        for (int k = 0; k < MAX_N; k++) begin
            sh[k] = src[k+1];
        end
        sh[MAX_N] = SYM_ZERO;
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_win       <= sh;
            r_eos       <= src_eos;
            r_out_sym   <= src[0];
            r_out_final <= src_eos && (src_left == CW'(1));
        end else if (o_pop) begin
            r_win <= ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_left <= src_left - 1'b1;
            end
            if (can_out) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_out_sym;
    assign o_final_symbol = r_out_final;

endmodule
`default_nettype wire

/* rtl/hdbn_line_encoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HDBn line encoder top level
// Streams one data bit per item in and ternary line symbols out.
// ----------------------------------------------------------------------------
// One bit is accepted per clock when the four-entry command queue has room.
// Output lags input by n symbols; in steady state each item releases one
// symbol, so throughput is one item per cycle while the output is not
// stalled. An end-of-stream item, or a lowered zeros_limit, releases up to
// MAX_N+1 symbols, one per cycle from the window register while the output
// is not stalled, and the queue absorbs input meanwhile. Each symbol reaches
// the output through the window and the output register.
module hdbn_line_encoder_top #(
    parameter int MAX_N = 7
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [hdbn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [hdbn_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_data_bit,
    input  wire                            i_end_of_stream,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic signed [1:0]              o_symbol,
    output logic                           o_final_symbol
);
    import hdbn_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    hdbn_front #(
        .MAX_N (MAX_N)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_bit      (i_data_bit),
        .i_end_of_stream (i_end_of_stream),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_cmd         (push_cmd)
    );

    hdbn_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    hdbn_back #(
        .MAX_N (MAX_N)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_symbol       (o_symbol),
        .o_final_symbol (o_final_symbol)
    );

`ifndef SYNTH
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_eos_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_cmd.eos) |-> (q_cmd.count != '0))
        else $error("end of stream item releases no symbol");

    a_b_slot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_cmd.b_pulse) |-> (q_cmd.b_slot <= q_cmd.pos))
        else $error("B pulse slot beyond window");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_cmd.count <= CNT_W'(MAX_N + 1)))
        else $error("release count exceeds window depth");
`endif

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn line encoder testbench
// Sends data bits through the encoder and keeps its own copy of the symbol
// window, the zero run, the last pulse and the violation sign. From these it
// works out the expected line symbols. Every symbol and its final flag is
// checked in order. Directed streams cover marks, violations with and
// without a B pulse, the shortest and longest zero limits, all first-mark
// codes and a limit change while symbols are held. Random streams follow,
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import hdbn_pkg::*;

    localparam int MAX_N           = 7;
    localparam int DRAIN_WAIT      = 40;
    localparam int ITEMS_PER_PHASE = 66;

    typedef struct {
        t_sym sym;
        logic fin;
    } t_line_out;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic                 i_data_bit      = 1'b0;
    logic                 i_end_of_stream = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic signed [1:0]    o_symbol;
    logic                 o_final_symbol;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int n_errors        = 0;

    logic [2:0] cfg_zeros_limit;
    logic       cfg_first_v_neg;
    t_sym       cfg_first_mark;

    t_sym       line_window [MAX_N+1];
    int         held_count;
    logic [2:0] zero_count;
    t_sym       last_mark;
    logic       next_v_neg;

    t_line_out  pending_symbols [$];

    hdbn_line_encoder_top #(
        .MAX_N(MAX_N)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_bit     (i_data_bit),
        .i_end_of_stream(i_end_of_stream),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_symbol       (o_symbol),
        .o_final_symbol (o_final_symbol)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void start_new_stream();
        zero_count = '0;
        last_mark  = (cfg_first_mark == SYM_NEG) ? SYM_POS : SYM_NEG;
        next_v_neg = cfg_first_v_neg;
    endfunction

    function automatic void reset_encoder_model();
        cfg_zeros_limit = RST_ZEROS_LIMIT;
        cfg_first_v_neg = RST_FIRST_V_NEG;
        cfg_first_mark  = RST_FIRST_MARK;
        foreach (line_window[k]) line_window[k] = SYM_ZERO;
        held_count = 0;
        start_new_stream();
    endfunction

    function automatic void encode_bit(logic b, logic eos);
        int        n;
        int        pos;
        int        k;
        t_sym      s;
        t_line_out r;
        n   = (cfg_zeros_limit > MAX_N) ? MAX_N : int'(cfg_zeros_limit);
        pos = (held_count > MAX_N) ? MAX_N : held_count;
        if (b) begin
            s          = (last_mark == SYM_POS) ? SYM_NEG : SYM_POS;
            last_mark  = s;
            zero_count = '0;
            line_window[pos] = s;
        end else if (zero_count >= n) begin
            s = next_v_neg ? SYM_NEG : SYM_POS;
            line_window[pos] = s;
            // retroactive B on the first zero of the run
            if (last_mark != s && pos >= n) line_window[pos-n] = s;
            last_mark  = s;
            zero_count = '0;
            next_v_neg = ~next_v_neg;
        end else begin
            line_window[pos] = SYM_ZERO;
            zero_count = zero_count + 3'd1;
        end
        held_count = pos + 1;
        while (held_count > n || (eos && held_count > 0)) begin
            r.sym = line_window[0];
            for (k = 1; k < held_count; k++) line_window[k-1] = line_window[k];
            line_window[held_count-1] = SYM_ZERO;
            held_count--;
            r.fin = eos && (held_count == 0);
            pending_symbols.push_back(r);
        end
        if (eos) start_new_stream();
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_line_out exp_out;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_symbols.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected symbol %0d final %0b",
                         $time, o_symbol, o_final_symbol);
            end else begin
                exp_out = pending_symbols.pop_front();
                if (o_symbol !== exp_out.sym) begin
                    n_errors++;
                    $display("%0t: symbol expected %0d actual %0d",
                             $time, exp_out.sym, o_symbol);
                end
                if (o_final_symbol !== exp_out.fin) begin
                    n_errors++;
                    $display("%0t: final_symbol expected %0b actual %0b",
                             $time, exp_out.fin, o_final_symbol);
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [2:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ZEROS_LIMIT: cfg_zeros_limit = val;
            CFG_FIRST_V_NEG: cfg_first_v_neg = val[0];
            CFG_FIRST_MARK:  cfg_first_mark  = t_sym'(val[1:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(logic [2:0] zl, logic [2:0] vneg, logic [2:0] mark);
        write_reg(CFG_ZEROS_LIMIT, zl);
        write_reg(CFG_FIRST_V_NEG, vneg);
        write_reg(CFG_FIRST_MARK, mark);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_bit(logic b, logic eos);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_data_bit      <= b;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (o_in_stall);
        encode_bit(b, eos);
    endtask

    task automatic send_run(logic [31:0] bits, int len, logic eos_last);
        for (int i = len - 1; i >= 0; i--) send_bit(bits[i], eos_last && i == 0);
    endtask

    // hold off until every expected symbol is out and the encoder is quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_default_hdb3();
        send_run(32'b1000010000, 10, 1'b1);
    endtask

    task automatic test_zero_limit();
        drain();
        set_config(3'd0, 3'b000, 3'b010);
        send_run(32'b0010, 4, 1'b1);
    endtask

    task automatic test_longest_limit();
        drain();
        set_config(3'd7, 3'b111, 3'b011);
        send_run(32'b100000000, 9, 1'b1);
    endtask

    task automatic test_limit_change_mid_stream();
        drain();
        set_config(3'd7, 3'b000, 3'b000);
        send_run(32'b1000, 4, 1'b0);
        drain();
        set_config(3'd1, 3'b001, 3'b001);
        send_run(32'b00, 2, 1'b1);
    endtask

    task automatic run_random_phase(int idle, int stall);
        int   sent;
        int   len;
        int   zero_pct;
        logic eos;
        drain();
        sender_idle_pct = idle;
        stall_pct       = stall;
        set_config(3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)));
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            len      = $urandom_range(24, 1);
            zero_pct = $urandom_range(90, 30);
            for (int i = 0; i < len; i++) begin
                eos = (i == len - 1) && ($urandom_range(7) != 0);
                send_bit($urandom_range(99) >= zero_pct, eos);
            end
            sent += len;
        end
    endtask

    task automatic test_random_streams();
        run_random_phase(0, 0);
        run_random_phase(82, 0);
        run_random_phase(0, 82);
        run_random_phase(26, 26);
    endtask

    initial begin
        reset_encoder_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_hdb3();
        test_zero_limit();
        test_longest_limit();
        test_limit_change_mid_stream();
        test_random_streams();
        drain();
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
